// ----- rtl/core/ptlru_pkg.sv -----
// Shared types and constants for the paged translation block.
`default_nettype none
package ptlru_pkg;
  localparam int MaxFrames = 64;
  localparam int FrameBits = $clog2(MaxFrames);
  localparam int PageBits = 20;
  localparam int OffsetBits = 12;
  localparam int PhysBits = 18;
  localparam int CfgBits = 7;
  localparam int PageDepth = 1 << PageBits;

  typedef struct packed {
    logic        kind;
    logic [31:0] virt_addr;
  } in_item_t;

  typedef struct packed {
    logic [PhysBits-1:0] physical_address;
    logic                page_fault;
    logic                evicted;
    logic                dirty_evicted;
    logic [31:0]         fault_count;
    logic [31:0]         dirty_evict_count;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input, bump clock, start page lookup
    logic clr_step;  // clearing pass: clear one valid row
    logic decide;    // lookup result available: hit update or scan start
    logic scan;      // one frame scanned
    logic commit;    // write miss result
    logic emit;      // present result
  } ptlru_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;
    logic hit;
    logic scan_last;
  } ptlru_sts_t;
endpackage
`default_nettype wire

// ----- rtl/core/ptlru_ctrl.sv -----
// Controller state machine for the paged translation block.
`default_nettype none
module ptlru_ctrl
  import ptlru_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  output ptlru_cmd_t      cmd,
  input  wire ptlru_sts_t sts
);
  localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_LOOK = 3'd2,
                         S_DEC = 3'd3, S_SCAN = 3'd4, S_COMMIT = 3'd5, S_EMIT = 3'd6;
  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: if (start) begin
        cmd.load = 1'b1;
        state_nxt = S_LOOK;
      end
      S_LOOK: state_nxt = S_DEC;
      S_DEC: begin
        cmd.decide = 1'b1;
        state_nxt = sts.hit ? S_EMIT : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else state_r <= state_nxt;
  end
endmodule
`default_nettype wire

// ----- rtl/core/ptlru_dp.sv -----
// Datapath: page table memories, frame tables, victim scan and counters.
`default_nettype none
module ptlru_dp
  import ptlru_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire in_item_t          in_item,
  input  wire logic              cfg_we,
  input  wire logic [CfgBits-1:0] cfg_wdata,
  input  wire ptlru_cmd_t        cmd,
  output ptlru_sts_t             sts,
  output logic                   out_valid,
  output out_item_t              out_item
);
  logic [CfgBits-1:0] cfg_r;
  logic               kind_r;
  logic [PageBits-1:0] page_r;
  logic [OffsetBits-1:0] offs_r;
  logic [31:0] clk_r, faults_r, dirties_r;

  // page table: valid bit and frame number in one word
  logic [FrameBits:0] ptab [PageDepth];
  logic [FrameBits:0] prd_r;
  logic [PageBits-1:0] clr_r;

  logic [MaxFrames-1:0] occ_r, clean_r;
  logic [31:0] age_r [MaxFrames];
  logic [PageBits-1:0] owner_r [MaxFrames];
  logic [31:0] age_rd_r;
  logic [PageBits-1:0] owner_rd_r;

  logic [FrameBits:0] scan_r;     // frame index under scan
  logic [FrameBits:0] nfr;        // usable frames
  logic have_empty_r, have_clean_r, have_any_r;
  logic [FrameBits-1:0] empty_r, cln_r, any_r;
  logic [31:0] cln_age_r, any_age_r;

  logic [FrameBits-1:0] frame_r;
  logic fault_r, evict_r, dirty_r;

  always_comb begin
    if (cfg_r == '0) nfr = (FrameBits+1)'(1);
    else if (cfg_r > CfgBits'(MaxFrames)) nfr = (FrameBits+1)'(MaxFrames);
    else nfr = (FrameBits+1)'(cfg_r);
  end

  logic [FrameBits-1:0] si;
  assign si = scan_r[FrameBits-1:0];
  assign sts.scan_last = (scan_r + 1'b1 >= nfr);
  assign sts.hit = prd_r[FrameBits];
  assign sts.clr_done = (clr_r == {PageBits{1'b1}});

  logic [FrameBits-1:0] victim;
  always_comb begin
    if (have_empty_r) victim = empty_r;
    else if (have_clean_r) victim = cln_r;
    else victim = any_r;
  end

  // page table port: one write address per cycle
  logic pt_we;
  logic [PageBits-1:0] pt_wa;
  logic [FrameBits:0] pt_wd;
  always_comb begin
    pt_we = 1'b0;
    pt_wa = page_r;
    pt_wd = '0;
    if (cmd.clr_step) begin
      pt_we = 1'b1;
      pt_wa = clr_r;
    end else if (cmd.commit) begin
      pt_we = 1'b1;
      pt_wd = {1'b1, victim};
    end else if (cmd.emit && evict_r && (owner_rd_r != page_r)) begin
      // invalidate evicted page on the cycle after commit
      pt_we = 1'b1;
      pt_wa = owner_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pt_we) ptab[pt_wa] <= pt_wd;
    prd_r <= ptab[page_r];
  end

  // age and owner memories: one write, registered reads
  // age read runs one frame ahead of the scan, primed with frame 0 at decide
  logic age_we;
  logic [FrameBits-1:0] age_wa, age_ra;
  always_comb begin
    age_we = 1'b0;
    age_wa = victim;
    if (cmd.decide && prd_r[FrameBits]) begin
      age_we = 1'b1;
      age_wa = prd_r[FrameBits-1:0];
    end else if (cmd.commit) begin
      age_we = 1'b1;
    end
  end
  assign age_ra = cmd.scan ? FrameBits'(si + 1'b1) : '0;

  always_ff @(posedge clk) begin
    if (age_we) age_r[age_wa] <= clk_r;
    if (cmd.commit) owner_r[victim] <= page_r;
    age_rd_r <= age_r[age_ra];
    owner_rd_r <= owner_r[victim];
  end

  logic found_empty_now, upd_clean, upd_any;
  assign found_empty_now = !occ_r[si] && !have_empty_r;
  assign upd_clean = occ_r[si] && clean_r[si] &&
                     (!have_clean_r || age_rd_r < cln_age_r);
  assign upd_any = occ_r[si] && (!have_any_r || age_rd_r < any_age_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CfgBits'(MaxFrames);
      clk_r <= '0; faults_r <= '0; dirties_r <= '0;
      occ_r <= '0; clean_r <= '1;
      clr_r <= '0; out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) cfg_r <= cfg_wdata;
      if (cmd.clr_step) clr_r <= clr_r + 1'b1;
      if (cmd.load) begin
        kind_r <= in_item.kind;
        page_r <= in_item.virt_addr[OffsetBits +: PageBits];
        offs_r <= in_item.virt_addr[OffsetBits-1:0];
        clk_r <= clk_r + 1'b1;
      end
      if (cmd.decide) begin
        scan_r <= '0;
        have_empty_r <= 1'b0; have_clean_r <= 1'b0; have_any_r <= 1'b0;
        fault_r <= !prd_r[FrameBits];
        evict_r <= 1'b0; dirty_r <= 1'b0;
        if (prd_r[FrameBits]) begin
          frame_r <= prd_r[FrameBits-1:0];
          if (kind_r) clean_r[prd_r[FrameBits-1:0]] <= 1'b0;
        end else begin
          faults_r <= faults_r + 1'b1;
        end
      end
      if (cmd.scan) begin
        scan_r <= scan_r + 1'b1;
        if (found_empty_now) begin
          have_empty_r <= 1'b1;
          empty_r <= si;
        end
        if (upd_clean) begin
          have_clean_r <= 1'b1; cln_r <= si; cln_age_r <= age_rd_r;
        end
        if (upd_any) begin
          have_any_r <= 1'b1; any_r <= si; any_age_r <= age_rd_r;
        end
      end
      if (cmd.commit) begin
        frame_r <= victim;
        if (!have_empty_r) begin
          evict_r <= 1'b1;
          if (!have_clean_r) begin
            dirty_r <= 1'b1;
            dirties_r <= dirties_r + 1'b1;
          end
        end
        occ_r[victim] <= 1'b1;
        clean_r[victim] <= !kind_r;
      end
      if (cmd.emit) out_valid <= 1'b1;
    end
  end

  always_comb begin
    out_item.physical_address = PhysBits'({frame_r, offs_r});
    out_item.page_fault = fault_r;
    out_item.evicted = evict_r;
    out_item.dirty_evicted = dirty_r;
    out_item.fault_count = faults_r;
    out_item.dirty_evict_count = dirties_r;
  end
endmodule
`default_nettype wire

// ----- rtl/core/paged_translation_lru_clean_first.sv -----
// Top level of the paged translation block with clean-first LRU replacement.
// After reset the block clears its 2^20-entry page table one row per cycle
// with busy high. From the edge that takes start, the controller loads the
// access, looks up its page and decides; a hit goes to emit, while a miss first
// runs a linear scan of one frame per cycle over the first n frames (n being the
// frame count written on cfg_wdata, clamped to 1..64) to find the empty, oldest
// clean and oldest frames, then commits the victim. busy is low in the cycle the
// result is shown, so the next transaction can start there. The result appears
// on the out_ ports for one cycle with out_valid high; the receiver cannot stall it.
`default_nettype none
module paged_translation_lru_clean_first
  import ptlru_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire in_item_t          in_item,
  input  wire logic              cfg_we,
  input  wire logic [CfgBits-1:0] cfg_wdata,
  output logic                   out_valid,
  output out_item_t              out_item
);
  ptlru_cmd_t cmd;
  ptlru_sts_t sts;

  ptlru_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
  );

  ptlru_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata), .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_item(out_item)
  );
endmodule
`default_nettype wire

// ----- tb/sv/ptlru_checker.sv -----
// Checker: predicts each translation result and compares it with the block's output.
module ptlru_checker
  import ptlru_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire in_item_t          in_item,
  input  wire logic              cfg_we,
  input  wire logic [CfgBits-1:0] cfg_wdata,
  input  wire logic              out_valid,
  input  wire out_item_t         out_item,
  output int                     fail_count,
  output int                     pending
);
  bit                 pg_valid [PageDepth];
  logic [FrameBits-1:0] pg_frame [PageDepth];
  bit                 fr_used  [MaxFrames];
  bit                 fr_clean [MaxFrames];
  logic [31:0]        fr_age   [MaxFrames];
  logic [PageBits-1:0] fr_page [MaxFrames];
  logic [31:0]        tick, faults, dirty_evicts;
  logic [CfgBits-1:0] frames_cfg;
  out_item_t          expected_q [$];

  function automatic int usable_frames();
    int n;
    n = int'(frames_cfg);
    if (n == 0) n = 1;
    if (n > MaxFrames) n = MaxFrames;
    return n;
  endfunction

  // oldest occupied frame below n; ties to the lowest index
  function automatic bit find_oldest(int n, bit clean_only, output int pick);
    bit found;
    found = 0;
    pick = 0;
    for (int i = 0; i < n; i++) begin
      if (fr_used[i] && (!clean_only || fr_clean[i]) &&
          (!found || fr_age[i] < fr_age[pick])) begin
        found = 1;
        pick = i;
      end
    end
    return found;
  endfunction

  function automatic out_item_t translate(in_item_t acc);
    out_item_t r;
    logic [PageBits-1:0] page;
    int frame, n;
    bit got_empty;
    page = acc.virt_addr[OffsetBits +: PageBits];
    r = '0;
    frame = 0;
    tick += 1;
    if (pg_valid[page]) begin
      frame = int'(pg_frame[page]);
      if (acc.kind) fr_clean[frame] = 0;
      fr_age[frame] = tick;
    end else begin
      n = usable_frames();
      got_empty = 0;
      r.page_fault = 1;
      faults += 1;
      for (int i = 0; i < n && !got_empty; i++) begin
        if (!fr_used[i]) begin
          frame = i;
          got_empty = 1;
        end
      end
      if (!got_empty) begin
        r.evicted = 1;
        if (!find_oldest(n, 1, frame)) begin
          r.dirty_evicted = 1;
          dirty_evicts += 1;
          void'(find_oldest(n, 0, frame));
        end
        pg_valid[fr_page[frame]] = 0;
      end
      fr_used[frame] = 1;
      fr_clean[frame] = !acc.kind;
      fr_age[frame] = tick;
      fr_page[frame] = page;
      pg_valid[page] = 1;
      pg_frame[page] = FrameBits'(frame);
    end
    r.physical_address = PhysBits'((frame << OffsetBits) | acc.virt_addr[OffsetBits-1:0]);
    r.fault_count = faults;
    r.dirty_evict_count = dirty_evicts;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      foreach (pg_valid[i]) pg_valid[i] = 0;
      foreach (fr_used[i]) begin
        fr_used[i] = 0;
        fr_clean[i] = 1;
        fr_age[i] = '0;
        fr_page[i] = '0;
      end
      tick = '0;
      faults = '0;
      dirty_evicts = '0;
      frames_cfg = CfgBits'(MaxFrames);
      fail_count <= 0;
      pending <= 0;
      expected_q.delete();
    end else begin
      if (cfg_we) frames_cfg = cfg_wdata;
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_item);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want !== out_item) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_item);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) expected_q.push_back(translate(in_item));
      pending <= expected_q.size();
    end
  end
endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench top: drives accesses and frame-count writes, gives the verdict.
module tb_top;
  import ptlru_pkg::*;

  logic clk = 0, rst_n = 0, start = 0, cfg_we = 0;
  logic [CfgBits-1:0] cfg_wdata = '0;
  in_item_t in_item = '0;
  logic busy, out_valid;
  out_item_t out_item;
  int fail_count, pending;
  int idle_cycles = 0;
  logic [19:0] hot_pages [8];

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  paged_translation_lru_clean_first dut (.*);
  ptlru_checker chk (.*);

  // watchdog: the clearing pass after reset also counts toward the idle limit
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 4200000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // start stays high after the accepting edge; a frame-count write or a nonzero
  // gap in the next call drops it, so back-to-back accesses need no extra assignment
  task automatic access(bit wr, logic [31:0] addr);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    in_item <= '{kind: wr, virt_addr: addr};
    start <= 1;
    do @(posedge clk); while (busy);
  endtask

  task automatic set_frames(logic [CfgBits-1:0] n);
    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_phase(int count, int pool);
    logic [31:0] a;
    for (int i = 0; i < count; i++) begin
      a = $urandom;
      if ($urandom_range(0, 9) != 0) a[31:12] = {$urandom_range(0, 3) == 0 ? a[31:15] : 17'h0,
                                                 3'(0)} | hot_pages[$urandom_range(0, pool - 1)];
      access(1'($urandom_range(0, 1)), a);
    end
  endtask

  initial begin
    foreach (hot_pages[i]) hot_pages[i] = 20'($urandom);
    repeat (6) @(posedge clk);
    rst_n <= 1;
    // directed: extremes, hits, writes, fills and evictions with few frames
    access(0, 32'h0000_0000);
    access(1, 32'hFFFF_FFFF);
    access(0, 32'hFFFF_F000);
    access(1, 32'h0000_0FFF);
    set_frames(7'd2);
    access(0, 32'h0001_0123);
    access(0, 32'h0002_0456); // clean eviction
    access(1, 32'h0003_0789);
    access(1, 32'h0001_0000);
    access(1, 32'h0004_0000); // dirty eviction
    access(0, 32'hFFFF_F555); // miss on a page evicted after the shrink
    set_frames(7'd0);         // treated as one frame
    access(1, 32'h0005_0001);
    access(0, 32'h0006_0002);
    set_frames(7'd127);       // saturates
    access(0, 32'hABCD_E123);
    access(1, 32'hABCD_E321);
    set_frames(7'd1);
    access(1, 32'h1234_5678);
    access(1, 32'h8765_4321);
    // random phases across frame counts, small hot page pools for reuse
    set_frames(7'd4);
    random_phase(100, 6);
    set_frames(7'd64);
    random_phase(100, 8);
    set_frames(7'd3);
    random_phase(100, 5);
    set_frames(7'd1);
    random_phase(40, 2);
    set_frames(7'($urandom_range(2, 10)));
    random_phase(110, 8);
    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
